// ===== src/baseline_press_release_detector_defines.svh =====
// Assertion helpers used by the detector RTL.
`ifndef BASELINE_PRESS_RELEASE_DETECTOR_DEFINES_SVH
`define BASELINE_PRESS_RELEASE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define BPRD_CHECK(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("bprd check failed");

`define BPRD_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bprd implication failed");

`define BPRD_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bprd sequence failed");

`else

`define BPRD_CHECK(name, expr)
`define BPRD_IMPLY(name, ante, cons)
`define BPRD_NEXT(name, ante, cons)

`endif

`endif

// ===== src/bprd_pkg.sv =====
package bprd_pkg;

    localparam int BTN_W   = 4;
    localparam int DEPTH_W = 16;
    localparam int THR_W   = 16;
    localparam int SUM_W   = 20;

    localparam logic [THR_W-1:0] THR_RESET = 16'd45;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_MOVE   = 1'b1;

    localparam logic EV_PRESSED  = 1'b0;
    localparam logic EV_RELEASED = 1'b1;

    typedef struct packed {
        logic               op;
        logic [BTN_W-1:0]   button;
        logic [DEPTH_W-1:0] depth;
        logic               moved;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [BTN_W-1:0] event_button;
        logic             event_kind;
        logic             event_last;
    } t_out_item;

endpackage

// ===== src/bprd_ram.sv =====
module bprd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/baseline_press_release_detector.sv =====
// Press/release detector over up to NUM_BUTTONS buttons with a self-learned depth
// baseline. Each input beat is taken in S_IDLE and handled in S_CALC: the button's
// baseline sum is read from a one-port-read memory, then updated or compared and
// written back. A frame_end sample beat that yields events is followed by a walk over
// the button masks, one button index per cycle while the output is not stalled,
// pressed group first and released group second, ending right after the last event.
// No new beat is taken during the walk. After reset or a surface move the first
// CALIB_FRAMES+1 frames calibrate and give no events. Result beats sit in an output
// register, so the next input beat is taken while an event still waits downstream.
module baseline_press_release_detector #(
    parameter int NUM_BUTTONS  = 16,
    parameter int CALIB_FRAMES = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bprd_pkg::THR_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    input  bprd_pkg::t_in_item                i_data,
    output logic                              o_stall,
    output logic                              o_valid,
    output bprd_pkg::t_out_item               o_data,
    input  logic                              i_stall
);

`include "baseline_press_release_detector_defines.svh"

    localparam int NB  = NUM_BUTTONS;
    localparam int AW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int CFW = $clog2(CALIB_FRAMES + 1);
    localparam int MW  = bprd_pkg::DEPTH_W + CFW;
    localparam int CW  = ((MW > bprd_pkg::SUM_W) ? MW : bprd_pkg::SUM_W) + 1;
    localparam int SW  = bprd_pkg::SUM_W;

    localparam logic [CFW-1:0] CF_K   = CFW'(CALIB_FRAMES);
    localparam logic [5:0]     NB_K   = 6'(NUM_BUTTONS);
    localparam logic [AW-1:0]  IDX_MX = AW'(NUM_BUTTONS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WALK_P,
        S_WALK_R
    } t_state;

    t_state              r_state;
    bprd_pkg::t_in_item  r_item;
    bprd_pkg::t_out_item r_odata;
    logic                r_ovalid;
    logic [bprd_pkg::THR_W-1:0] r_thr;
    logic [NB-1:0]       r_known;
    logic [NB-1:0]       r_now;
    logic [NB-1:0]       r_before;
    logic [NB-1:0]       r_evp;
    logic [NB-1:0]       r_evr;
    logic                r_calib;
    logic [CFW-1:0]      r_cframe;
    logic                r_moved;
    logic                r_moved_b;
    logic [AW-1:0]       r_widx;

    logic [AW-1:0]       bidx;
    logic                bvalid;
    logic                active;
    logic                do_smp;
    logic                ram_we;
    logic [SW-1:0]       ram_wdata;
    logic [SW-1:0]       ram_rdata;
    logic [AW-1:0]       ram_raddr;
    logic [SW:0]         sum_ext;
    logic [SW-1:0]       sum_sat;
    logic [MW-1:0]       lhs;
    logic [MW-1:0]       thr_x;
    logic [CW-1:0]       rhs;
    logic                hit;
    logic                set_known;
    logic [NB-1:0]       n_now;
    logic [NB-1:0]       n_newp;
    logic [NB-1:0]       n_newr;
    logic                cur;
    logic [NB-1:0]       rem_p;
    logic [NB-1:0]       rem_r;
    logic                walk_done;
    logic                out_free;
    logic                emit;

    bprd_ram #(
        .WIDTH (SW),
        .DEPTH (NB)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (bidx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = AW'(i_data.button);
    assign out_free  = !r_ovalid || !i_stall;

    // sample path: memory data arrives in S_CALC for the beat taken in S_IDLE
    always_comb begin
        bidx      = AW'(r_item.button);
        bvalid    = {2'b00, r_item.button} < NB_K;
        active    = !r_moved && !r_moved_b;
        do_smp    = (r_item.op == bprd_pkg::OP_SAMPLE) && active && bvalid;
        sum_ext   = {1'b0, ram_rdata} + (SW + 1)'(r_item.depth);
        sum_sat   = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
        // depth > avg + thr, scaled by CALIB_FRAMES to stay exact
        lhs       = {{CFW{1'b0}}, r_item.depth} * {{bprd_pkg::DEPTH_W{1'b0}}, CF_K};
        thr_x     = {{CFW{1'b0}}, r_thr} * {{bprd_pkg::DEPTH_W{1'b0}}, CF_K};
        rhs       = CW'(ram_rdata) + CW'(thr_x);
        ram_we    = 1'b0;
        ram_wdata = sum_sat;
        hit       = 1'b0;
        set_known = 1'b0;
        if (r_state == S_CALC && do_smp) begin
            if (r_calib) begin
                if (r_cframe == '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = SW'(r_item.depth);
                    set_known = 1'b1;
                end else if (r_cframe < CF_K && r_known[bidx]) begin
                    ram_we = 1'b1;
                end
            end else if (r_known[bidx] && (CW'(lhs) > rhs)) begin
                hit = 1'b1;
            end
        end
        n_now = r_now;
        if (hit) begin
            n_now[bidx] = 1'b1;
        end
        n_newp = n_now & ~r_before;
        n_newr = r_before & ~n_now;
    end

    // event walk: last flag comes from what is left in both masks
    always_comb begin
        rem_p = r_evp;
        rem_r = r_evr;
        if (r_state == S_WALK_R) begin
            cur = r_evr[r_widx];
            rem_r[r_widx] = 1'b0;
        end else begin
            cur = r_evp[r_widx];
            rem_p[r_widx] = 1'b0;
        end
        walk_done = (rem_p | rem_r) == '0;
        emit      = (r_state inside {S_WALK_P, S_WALK_R}) && out_free && cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_thr     <= bprd_pkg::THR_RESET;
            r_known   <= '0;
            r_now     <= '0;
            r_before  <= '0;
            r_evp     <= '0;
            r_evr     <= '0;
            r_calib   <= 1'b1;
            r_cframe  <= '0;
            r_moved   <= 1'b0;
            r_moved_b <= 1'b0;
            r_widx    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_data;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_IDLE;
                    if (set_known) begin
                        r_known[bidx] <= 1'b1;
                    end
                    if (r_item.op == bprd_pkg::OP_MOVE) begin
                        r_moved <= r_item.moved;
                        if (r_item.moved) begin
                            r_known  <= '0;
                            r_now    <= '0;
                            r_before <= '0;
                            r_calib  <= 1'b1;
                            r_cframe <= '0;
                        end
                    end else if (r_item.frame_end) begin
                        r_moved_b <= r_moved;
                        r_now     <= '0;
                        if (active) begin
                            r_evp    <= n_newp;
                            r_evr    <= n_newr;
                            r_before <= n_now;
                            r_widx   <= '0;
                            if (r_calib) begin
                                if (r_cframe >= CF_K) begin
                                    r_calib <= 1'b0;
                                end else begin
                                    r_cframe <= r_cframe + 1'b1;
                                end
                            end
                            if ((n_newp | n_newr) != '0) begin
                                r_state <= S_WALK_P;
                            end
                        end else if (r_moved_b && !r_moved) begin
                            // move flag just dropped: learn the surface again
                            r_known  <= '0;
                            r_before <= '0;
                            r_calib  <= 1'b1;
                            r_cframe <= '0;
                        end
                    end else begin
                        r_now <= n_now;
                    end
                end
                S_WALK_P, S_WALK_R: begin
                    if (out_free) begin
                        if (cur) begin
                            r_odata.event_button   <= bprd_pkg::BTN_W'(r_widx);
                            r_odata.event_kind     <= (r_state == S_WALK_R) ?
                                                      bprd_pkg::EV_RELEASED :
                                                      bprd_pkg::EV_PRESSED;
                            r_odata.event_last     <= walk_done;
                        end
                        r_evp <= rem_p;
                        r_evr <= rem_r;
                        if (walk_done) begin
                            r_state <= S_IDLE;
                        end else if (r_widx == IDX_MX) begin
                            r_widx  <= '0;
                            r_state <= S_WALK_R;
                        end else begin
                            r_widx <= r_widx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    `BPRD_NEXT(a_accept_calc, i_valid && !o_stall, r_state == S_CALC)
    `BPRD_IMPLY(a_walk_pending, r_state == S_WALK_P || r_state == S_WALK_R, (r_evp | r_evr) != '0)
    `BPRD_IMPLY(a_calib_done, !r_calib, r_cframe == CF_K)
    `BPRD_CHECK(a_pressed_known, ((r_now | r_before) & ~r_known) == '0)

endmodule
